### rtl/core/wrms_pkg.sv
package wrms_pkg;

  localparam int DEF_SAMPLE_WIDTH = 16;
  localparam int DEF_SUM_WIDTH    = 64;

  localparam int WEIGHT_W    = 16;
  localparam int PERIOD_W    = 32;
  localparam int LEVEL_W     = 16;
  localparam int RAD_W       = 2 * LEVEL_W;
  localparam int ROOT_STEPS  = LEVEL_W;
  localparam int NUM_CH      = 3;
  localparam int CH_W        = $clog2(NUM_CH);
  localparam int QUEUE_DEPTH = 2;
  localparam int OP_W        = 2;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;

  // work classified by the front end
  typedef enum logic [OP_W-1:0] {
    OP_NOP  = 2'd0,
    OP_ACC  = 2'd1,
    OP_ZERO = 2'd2,
    OP_DIV  = 2'd3
  } op_t;

  // command word: op, three samples, weight, period (lowest first)
  function automatic int cmd_width(input int sample_w);
    return OP_W + NUM_CH * sample_w + WEIGHT_W + PERIOD_W;
  endfunction

endpackage

### rtl/core/wrms_queue.sv
module wrms_queue #(
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_valid,
  output logic              wr_ready,
  input  logic [DATA_W-1:0] wr_data,
  output logic              rd_valid,
  input  logic              rd_ready,
  output logic [DATA_W-1:0] rd_data
);

  localparam int DEPTH = wrms_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              push, pop;

  assign wr_ready = (count_r != CNT_W'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_r + 1'b1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_r + 1'b1);
    end
    if (push && !pop) begin
      count_nxt = CNT_W'(count_r + 1'b1);
    end else if (pop && !push) begin
      count_nxt = CNT_W'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

### rtl/core/wrms_front.sv
module wrms_front #(
  parameter int SAMPLE_WIDTH = wrms_pkg::DEF_SAMPLE_WIDTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic                              cfg_wr_data,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic                              kind,
  input  logic [SAMPLE_WIDTH-1:0]           position_sample,
  input  logic [SAMPLE_WIDTH-1:0]           speed_sample,
  input  logic [SAMPLE_WIDTH-1:0]           torque_sample,
  input  logic [wrms_pkg::WEIGHT_W-1:0]     time_weight,
  input  logic [wrms_pkg::PERIOD_W-1:0]     period_length,
  output logic                              cmd_valid,
  input  logic                              cmd_ready,
  output logic [wrms_pkg::cmd_width(SAMPLE_WIDTH)-1:0] cmd_data
);

  logic           enable_r, enable_nxt;
  wrms_pkg::op_t  op;

  assign enable_nxt = cfg_wr_en ? cfg_wr_data : enable_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
    end else begin
      enable_r <= enable_nxt;
    end
  end

  // disabled words still return the stored levels, so they pass as no-ops
  always_comb begin
    if (!enable_r) begin
      op = wrms_pkg::OP_NOP;
    end else if (!kind) begin
      op = wrms_pkg::OP_ACC;
    end else if (period_length == '0) begin
      op = wrms_pkg::OP_ZERO;
    end else begin
      op = wrms_pkg::OP_DIV;
    end
  end

  assign cmd_valid = in_tvalid;
  assign in_tready = cmd_ready;
  assign cmd_data  = {period_length, time_weight, torque_sample, speed_sample,
                      position_sample, op};

endmodule

### rtl/core/wrms_back.sv
module wrms_back #(
  parameter int SAMPLE_WIDTH = wrms_pkg::DEF_SAMPLE_WIDTH,
  parameter int SUM_WIDTH    = wrms_pkg::DEF_SUM_WIDTH
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         cmd_valid,
  output logic                                         cmd_ready,
  input  logic [wrms_pkg::cmd_width(SAMPLE_WIDTH)-1:0] cmd_data,
  output logic                                         out_tvalid,
  input  logic                                         out_tready,
  output logic [wrms_pkg::LEVEL_W-1:0]                 position_rms,
  output logic [wrms_pkg::LEVEL_W-1:0]                 speed_rms,
  output logic [wrms_pkg::LEVEL_W-1:0]                 torque_rms,
  output logic                                         zero_period
);

  localparam int SW     = SAMPLE_WIDTH;
  localparam int NCH    = wrms_pkg::NUM_CH;
  localparam int LW     = wrms_pkg::LEVEL_W;
  localparam int WW     = wrms_pkg::WEIGHT_W;
  localparam int PERW   = wrms_pkg::PERIOD_W;
  localparam int RADW   = wrms_pkg::RAD_W;
  localparam int SQ_W   = 2 * SW;
  localparam int PROD_W = SQ_W + WW;
  localparam int ADD_W  = ((PROD_W > SUM_WIDTH) ? PROD_W : SUM_WIDTH) + 1;
  localparam int CNT_W  = $clog2(SUM_WIDTH);
  localparam int RR_W   = LW + 2;
  localparam int OPW    = wrms_pkg::OP_W;
  localparam int SMP_LO = OPW;
  localparam int WT_LO  = OPW + NCH * SW;
  localparam int PER_LO = WT_LO + WW;

  localparam logic [SUM_WIDTH-1:0] SUM_MAX = '1;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_SQ   = 7'b0000010,
    ST_WT   = 7'b0000100,
    ST_ADD  = 7'b0001000,
    ST_DIV  = 7'b0010000,
    ST_ROOT = 7'b0100000,
    ST_DONE = 7'b1000000
  } state_t;

  state_t                  state_r, state_nxt;
  logic [SUM_WIDTH-1:0]    sum_r   [NCH];
  logic [SUM_WIDTH-1:0]    sum_nxt [NCH];
  logic [LW-1:0]           level_r   [NCH];
  logic [LW-1:0]           level_nxt [NCH];
  logic                    zero_r, zero_nxt;
  logic [SW-1:0]           mag_r   [NCH];
  logic [SW-1:0]           mag_nxt [NCH];
  logic [SQ_W-1:0]         sq_r    [NCH];
  logic [SQ_W-1:0]         sq_nxt  [NCH];
  logic [PROD_W-1:0]       prod_r  [NCH];
  logic [PROD_W-1:0]       prod_nxt[NCH];
  logic [WW-1:0]           weight_r, weight_nxt;
  logic [PERW-1:0]         period_r, period_nxt;
  logic [SUM_WIDTH-1:0]    dvd_r, dvd_nxt;
  logic [PERW-1:0]         rem_r, rem_nxt;
  logic [RADW-1:0]         rad_r, rad_nxt;
  logic [RR_W-1:0]         rrem_r, rrem_nxt;
  logic [LW-1:0]           root_r, root_nxt;
  logic                    sat_r, sat_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [wrms_pkg::CH_W-1:0] ch_r, ch_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [LW-1:0]           out_level_r   [NCH];
  logic [LW-1:0]           out_level_nxt [NCH];
  logic                    out_zero_r, out_zero_nxt;

  wrms_pkg::op_t           cmd_op;
  logic [SW-1:0]           cmd_smp [NCH];
  logic [ADD_W-1:0]        add_s   [NCH];
  logic [PERW:0]           div_sh, div_diff;
  logic                    div_ge;
  logic [SUM_WIDTH-1:0]    quo;
  logic [RR_W+1:0]         rt_cur, rt_trial, rt_diff;
  logic                    rt_ge;
  logic [LW-1:0]           root_step;
  logic                    ch_last;

  assign cmd_op = wrms_pkg::op_t'(cmd_data[OPW-1:0]);
  assign cmd_ready = (state_r == ST_IDLE);

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      cmd_smp[c] = cmd_data[SMP_LO + c*SW +: SW];
      add_s[c]   = ADD_W'(sum_r[c]) + ADD_W'(prod_r[c]);
    end
  end

  // restoring divide, one quotient bit per cycle
  assign div_sh   = {rem_r, dvd_r[SUM_WIDTH-1]};
  assign div_diff = div_sh - {1'b0, period_r};
  assign div_ge   = (div_sh >= {1'b0, period_r});
  assign quo      = {dvd_r[SUM_WIDTH-2:0], div_ge};

  // digit-by-digit root, two radicand bits per cycle
  assign rt_cur    = {rrem_r, rad_r[RADW-1 -: 2]};
  assign rt_trial  = (RR_W+2)'({root_r, 2'b01});
  assign rt_ge     = (rt_cur >= rt_trial);
  assign rt_diff   = rt_cur - rt_trial;
  assign root_step = {root_r[LW-2:0], rt_ge};
  assign ch_last   = (ch_r == wrms_pkg::CH_W'(NCH - 1));

  always_comb begin
    state_nxt     = state_r;
    sum_nxt       = sum_r;
    level_nxt     = level_r;
    zero_nxt      = zero_r;
    mag_nxt       = mag_r;
    sq_nxt        = sq_r;
    prod_nxt      = prod_r;
    weight_nxt    = weight_r;
    period_nxt    = period_r;
    dvd_nxt       = dvd_r;
    rem_nxt       = rem_r;
    rad_nxt       = rad_r;
    rrem_nxt      = rrem_r;
    root_nxt      = root_r;
    sat_nxt       = sat_r;
    cnt_nxt       = cnt_r;
    ch_nxt        = ch_r;
    out_valid_nxt = out_valid_r;
    out_level_nxt = out_level_r;
    out_zero_nxt  = out_zero_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          case (cmd_op)
            wrms_pkg::OP_ACC: begin
              for (int c = 0; c < NCH; c++) begin
                mag_nxt[c] = cmd_smp[c][SW-1] ? SW'(~cmd_smp[c] + 1'b1) : cmd_smp[c];
              end
              weight_nxt = cmd_data[WT_LO +: WW];
              state_nxt  = ST_SQ;
            end
            wrms_pkg::OP_ZERO: begin
              for (int c = 0; c < NCH; c++) begin
                level_nxt[c] = wrms_pkg::LEVEL_MAX;
                sum_nxt[c]   = '0;
              end
              zero_nxt  = 1'b1;
              state_nxt = ST_DONE;
            end
            wrms_pkg::OP_DIV: begin
              period_nxt = cmd_data[PER_LO +: PERW];
              ch_nxt     = '0;
              dvd_nxt    = sum_r[0];
              rem_nxt    = '0;
              cnt_nxt    = CNT_W'(SUM_WIDTH - 1);
              state_nxt  = ST_DIV;
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end
      ST_SQ: begin
        for (int c = 0; c < NCH; c++) begin
          sq_nxt[c] = SQ_W'(mag_r[c] * mag_r[c]);
        end
        state_nxt = ST_WT;
      end
      ST_WT: begin
        for (int c = 0; c < NCH; c++) begin
          prod_nxt[c] = PROD_W'(sq_r[c] * weight_r);
        end
        state_nxt = ST_ADD;
      end
      ST_ADD: begin
        for (int c = 0; c < NCH; c++) begin
          sum_nxt[c] = (add_s[c] > ADD_W'(SUM_MAX)) ? SUM_MAX : add_s[c][SUM_WIDTH-1:0];
        end
        state_nxt = ST_DONE;
      end
      ST_DIV: begin
        rem_nxt = div_ge ? div_diff[PERW-1:0] : div_sh[PERW-1:0];
        dvd_nxt = quo;
        cnt_nxt = CNT_W'(cnt_r - 1'b1);
        if (cnt_r == '0) begin
          // a quotient of 2^32 or more has a root past the level range
          sat_nxt   = ((quo >> RADW) != '0);
          rad_nxt   = quo[RADW-1:0];
          rrem_nxt  = '0;
          root_nxt  = '0;
          cnt_nxt   = CNT_W'(wrms_pkg::ROOT_STEPS - 1);
          state_nxt = ST_ROOT;
        end
      end
      ST_ROOT: begin
        rrem_nxt = rt_ge ? rt_diff[RR_W-1:0] : rt_cur[RR_W-1:0];
        root_nxt = root_step;
        rad_nxt  = {rad_r[RADW-3:0], 2'b00};
        cnt_nxt  = CNT_W'(cnt_r - 1'b1);
        if (cnt_r == '0) begin
          level_nxt[ch_r] = sat_r ? wrms_pkg::LEVEL_MAX : root_step;
          sum_nxt[ch_r]   = '0;
          if (ch_last) begin
            zero_nxt  = 1'b0;
            state_nxt = ST_DONE;
          end else begin
            ch_nxt    = wrms_pkg::CH_W'(ch_r + 1'b1);
            dvd_nxt   = sum_r[wrms_pkg::CH_W'(ch_r + 1'b1)];
            rem_nxt   = '0;
            cnt_nxt   = CNT_W'(SUM_WIDTH - 1);
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_level_nxt = level_r;
          out_zero_nxt  = zero_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      zero_r      <= 1'b0;
      for (int c = 0; c < NCH; c++) begin
        sum_r[c]   <= '0;
        level_r[c] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      zero_r      <= zero_nxt;
      sum_r       <= sum_nxt;
      level_r     <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r       <= mag_nxt;
    sq_r        <= sq_nxt;
    prod_r      <= prod_nxt;
    weight_r    <= weight_nxt;
    period_r    <= period_nxt;
    dvd_r       <= dvd_nxt;
    rem_r       <= rem_nxt;
    rad_r       <= rad_nxt;
    rrem_r      <= rrem_nxt;
    root_r      <= root_nxt;
    sat_r       <= sat_nxt;
    cnt_r       <= cnt_nxt;
    ch_r        <= ch_nxt;
    out_level_r <= out_level_nxt;
    out_zero_r  <= out_zero_nxt;
  end

  assign out_tvalid   = out_valid_r;
  assign position_rms = out_level_r[0];
  assign speed_rms    = out_level_r[1];
  assign torque_rms   = out_level_r[2];
  assign zero_period  = out_zero_r;

endmodule

### rtl/core/weighted_rms_three_channel_core.sv
// channel  | handshake           | tdata (low bit up)                       | tuser
// ---------+---------------------+------------------------------------------+------------
// in_      | in_tvalid/in_tready | position, speed, torque, weight, period  | kind
// out_     | out_tvalid/out_tready | position_rms, speed_rms, torque_rms    | zero_period
// cfg_     | cfg_wr_en           | cfg_wr_data: enable                      | -
//
// one word is worked at a time by the back end; a two-entry command queue sits in front
// sample words pass the square, weight and add states; disabled words and zero periods
// go straight to done; a nonzero period end runs through the shared one-bit-per-cycle
// divider and the two-bit-per-cycle root unit, walked per channel
// rst_n is synchronous; it clears enable, the sums, the levels and the flag
// a stalled result sits in the output register while the queue takes words until full
module weighted_rms_three_channel_core #(
  parameter int SAMPLE_WIDTH = wrms_pkg::DEF_SAMPLE_WIDTH,
  parameter int SUM_WIDTH    = wrms_pkg::DEF_SUM_WIDTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_wr_en,
  input  logic cfg_wr_data,
  input  logic in_tvalid,
  output logic in_tready,
  // position, speed, torque samples, time_weight, period_length, zero fill
  input  logic [((3*SAMPLE_WIDTH + wrms_pkg::WEIGHT_W + wrms_pkg::PERIOD_W + 7) / 8) * 8 - 1:0]
               in_tdata,
  // kind
  input  logic in_tuser,
  output logic out_tvalid,
  input  logic out_tready,
  // position_rms, speed_rms, torque_rms
  output logic [3*wrms_pkg::LEVEL_W-1:0] out_tdata,
  // zero_period
  output logic out_tuser
);

  localparam int SW    = SAMPLE_WIDTH;
  localparam int WT_LO = 3 * SW;
  localparam int PR_LO = WT_LO + wrms_pkg::WEIGHT_W;
  localparam int CMD_W = wrms_pkg::cmd_width(SAMPLE_WIDTH);

  logic                         f_cmd_valid, f_cmd_ready;
  logic [CMD_W-1:0]             f_cmd_data;
  logic                         b_cmd_valid, b_cmd_ready;
  logic [CMD_W-1:0]             b_cmd_data;
  logic [wrms_pkg::LEVEL_W-1:0] position_rms, speed_rms, torque_rms;

  wrms_front #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .kind           (in_tuser),
    .position_sample(in_tdata[SW-1:0]),
    .speed_sample   (in_tdata[2*SW-1:SW]),
    .torque_sample  (in_tdata[3*SW-1:2*SW]),
    .time_weight    (in_tdata[WT_LO +: wrms_pkg::WEIGHT_W]),
    .period_length  (in_tdata[PR_LO +: wrms_pkg::PERIOD_W]),
    .cmd_valid      (f_cmd_valid),
    .cmd_ready      (f_cmd_ready),
    .cmd_data       (f_cmd_data)
  );

  wrms_queue #(
    .DATA_W(CMD_W)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_valid(f_cmd_valid),
    .wr_ready(f_cmd_ready),
    .wr_data (f_cmd_data),
    .rd_valid(b_cmd_valid),
    .rd_ready(b_cmd_ready),
    .rd_data (b_cmd_data)
  );

  wrms_back #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .SUM_WIDTH   (SUM_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (b_cmd_valid),
    .cmd_ready   (b_cmd_ready),
    .cmd_data    (b_cmd_data),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .position_rms(position_rms),
    .speed_rms   (speed_rms),
    .torque_rms  (torque_rms),
    .zero_period (out_tuser)
  );

  assign out_tdata = {torque_rms, speed_rms, position_rms};

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int IN_W = ((3 * wrms_pkg::DEF_SAMPLE_WIDTH + wrms_pkg::WEIGHT_W
                          + wrms_pkg::PERIOD_W + 7) / 8) * 8;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_END    = 1'b1;

  localparam logic [1:0] CFG_KEEP = 2'd0;
  localparam logic [1:0] CFG_OFF  = 2'd1;
  localparam logic [1:0] CFG_ON   = 2'd2;

  localparam logic PREDICT = 1'b0;
  localparam logic TYPED   = 1'b1;

  localparam int PHASES      = 6;
  localparam int PHASE_WORDS = 238;
  localparam int HOLD_AT     = 400;
  localparam int HOLD_CYCLES = 600;
  localparam int DRILL_N     = 25;

  localparam logic PHASE_EN [PHASES] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};

  typedef struct packed {
    logic [31:0]                          period;
    logic [15:0]                          weight;
    logic [wrms_pkg::NUM_CH-1:0][15:0]    smp;     // position, speed, torque from index 0
    logic                                 kind;
  } meter_word_t;

  typedef struct packed {
    logic        zero;
    logic [15:0] torque;
    logic [15:0] speed;
    logic [15:0] position;
  } rms_levels_t;

  typedef struct packed {
    logic [1:0]  cfg;
    logic        kind;
    logic [15:0] pos, spd, trq, weight;
    logic [31:0] period;
    logic        typed;
    logic [15:0] e_pos, e_spd, e_trq;
    logic        e_zero;
  } drill_row_t;

  // cfg, kind, position, speed, torque, weight, period, check, expected levels and flag
  localparam drill_row_t DRILL [DRILL_N] = '{
    // disabled after reset: nothing moves
    '{CFG_KEEP, KIND_SAMPLE, 16'h7fff, 16'h8000, 16'h7fff, 16'hffff, 32'h0000_0000,
      TYPED, 16'h0000, 16'h0000, 16'h0000, 1'b0},
    '{CFG_KEEP, KIND_END, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0000_0000,
      TYPED, 16'h0000, 16'h0000, 16'h0000, 1'b0},
    '{CFG_KEEP, KIND_END, 16'h1234, 16'h5678, 16'h9abc, 16'hdef0, 32'h0000_0001,
      TYPED, 16'h0000, 16'h0000, 16'h0000, 1'b0},
    // full-scale position and speed at max weight, then a one-tick period saturates the root
    '{CFG_ON, KIND_SAMPLE, 16'h8000, 16'h7fff, 16'h0000, 16'hffff, 32'h0000_0000,
      TYPED, 16'h0000, 16'h0000, 16'h0000, 1'b0},
    '{CFG_KEEP, KIND_END, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0000_0001,
      TYPED, 16'hffff, 16'hffff, 16'h0000, 1'b0},
    '{CFG_KEEP, KIND_SAMPLE, 16'h0003, 16'hfffc, 16'h0005, 16'h0001, 32'h0000_0000,
      TYPED, 16'hffff, 16'hffff, 16'h0000, 1'b0},
    '{CFG_KEEP, KIND_END, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0000_0001,
      TYPED, 16'h0003, 16'h0004, 16'h0005, 1'b0},
    // zero-length period, then a nonzero one clears the flag
    '{CFG_KEEP, KIND_END, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0000_0000,
      TYPED, 16'hffff, 16'hffff, 16'hffff, 1'b1},
    '{CFG_KEEP, KIND_END, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0000_0007,
      TYPED, 16'h0000, 16'h0000, 16'h0000, 1'b0},
    '{CFG_KEEP, KIND_SAMPLE, 16'hffff, 16'h0001, 16'h8001, 16'h0000, 32'h0000_0000,
      PREDICT, 16'h0000, 16'h0000, 16'h0000, 1'b0},
    '{CFG_KEEP, KIND_SAMPLE, 16'h0064, 16'hff38, 16'h012c, 16'h000a, 32'h0000_0000,
      PREDICT, 16'h0000, 16'h0000, 16'h0000, 1'b0},
    '{CFG_KEEP, KIND_SAMPLE, 16'h8000, 16'h8000, 16'h8000, 16'hffff, 32'h0000_0000,
      PREDICT, 16'h0000, 16'h0000, 16'h0000, 1'b0},
    '{CFG_KEEP, KIND_END, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'hffff_ffff,
      PREDICT, 16'h0000, 16'h0000, 16'h0000, 1'b0},
    '{CFG_KEEP, KIND_SAMPLE, 16'h1000, 16'he000, 16'h7fff, 16'h0100, 32'h0000_0000,
      PREDICT, 16'h0000, 16'h0000, 16'h0000, 1'b0},
    '{CFG_KEEP, KIND_SAMPLE, 16'h0001, 16'h0002, 16'h0003, 16'h8000, 32'h0000_0000,
      PREDICT, 16'h0000, 16'h0000, 16'h0000, 1'b0},
    '{CFG_KEEP, KIND_END, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0001_8100,
      PREDICT, 16'h0000, 16'h0000, 16'h0000, 1'b0},
    '{CFG_KEEP, KIND_SAMPLE, 16'h7fff, 16'h7fff, 16'h7fff, 16'hffff, 32'h0000_0000,
      PREDICT, 16'h0000, 16'h0000, 16'h0000, 1'b0},
    '{CFG_KEEP, KIND_END, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0000_0000,
      TYPED, 16'hffff, 16'hffff, 16'hffff, 1'b1},
    // disabled again: levels and flag hold
    '{CFG_OFF, KIND_SAMPLE, 16'h7fff, 16'h7fff, 16'h7fff, 16'hffff, 32'h0000_0000,
      TYPED, 16'hffff, 16'hffff, 16'hffff, 1'b1},
    '{CFG_KEEP, KIND_END, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0000_0005,
      TYPED, 16'hffff, 16'hffff, 16'hffff, 1'b1},
    '{CFG_ON, KIND_END, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0000_0003,
      TYPED, 16'h0000, 16'h0000, 16'h0000, 1'b0},
    '{CFG_KEEP, KIND_SAMPLE, 16'h5555, 16'haaaa, 16'h00ff, 16'h5555, 32'h0000_0000,
      PREDICT, 16'h0000, 16'h0000, 16'h0000, 1'b0},
    '{CFG_KEEP, KIND_END, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'haaaa_aaaa,
      PREDICT, 16'h0000, 16'h0000, 16'h0000, 1'b0},
    '{CFG_KEEP, KIND_SAMPLE, 16'h2aaa, 16'hd555, 16'hff00, 16'haaaa, 32'h0000_0000,
      PREDICT, 16'h0000, 16'h0000, 16'h0000, 1'b0},
    '{CFG_KEEP, KIND_END, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h5555_5555,
      PREDICT, 16'h0000, 16'h0000, 16'h0000, 1'b0}
  };

  logic                              clk;
  logic                              rst_n;
  logic                              cfg_wr_en;
  logic                              cfg_wr_data;
  logic                              in_tvalid;
  logic                              in_tready;
  logic [IN_W-1:0]                   in_tdata;   // position, speed, torque, time_weight, period
  logic                              in_tuser;   // kind
  logic                              out_tvalid;
  logic                              out_tready;
  logic [3*wrms_pkg::LEVEL_W-1:0]    out_tdata;  // position_rms, speed_rms, torque_rms
  logic                              out_tuser;  // zero_period

  // predictor state
  bit                                meter_on;
  logic [63:0]                       ch_sum   [wrms_pkg::NUM_CH];
  logic [15:0]                       ch_level [wrms_pkg::NUM_CH];
  logic                              zero_seen;

  rms_levels_t                       levels_due [$];

  int words_sent;
  int results_seen;
  int ends_done;
  int zero_ends;
  int cfg_writes;
  int mismatches;
  bit sender_rush;
  bit taker_rush;
  bit held;

  weighted_rms_three_channel_core DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("%0t: run stalled, %0d words sent, %0d results seen",
             $time, words_sent, results_seen);
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic rms_levels_t meter_step(input meter_word_t wd);
    logic [16:0] mag;
    logic [64:0] total;
    logic [63:0] quo;
    logic [31:0] root;
    logic [31:0] trial;
    rms_levels_t lv;
    if (meter_on && wd.kind == KIND_SAMPLE) begin
      for (int c = 0; c < wrms_pkg::NUM_CH; c++) begin
        // 17 bits so that -32768 has a magnitude
        mag = wd.smp[c][15] ? 17'd0 - {1'b1, wd.smp[c]} : {1'b0, wd.smp[c]};
        total = {1'b0, ch_sum[c]}
              + {1'b0, {47'd0, mag} * {47'd0, mag} * {48'd0, wd.weight}};
        ch_sum[c] = total[64] ? '1 : total[63:0];
      end
    end else if (meter_on) begin
      for (int c = 0; c < wrms_pkg::NUM_CH; c++) begin
        if (wd.period == '0) begin
          ch_level[c] = wrms_pkg::LEVEL_MAX;
        end else begin
          quo = ch_sum[c] / {32'd0, wd.period};
          root = '0;
          // floor root, one bit at a time from the top
          for (int b = 31; b >= 0; b--) begin
            trial = root | (32'd1 << b);
            if ({32'd0, trial} * {32'd0, trial} <= quo) root = trial;
          end
          ch_level[c] = (root > 32'h0000_ffff) ? wrms_pkg::LEVEL_MAX : root[15:0];
        end
        ch_sum[c] = '0;
      end
      zero_seen = (wd.period == '0);
      ends_done++;
      if (zero_seen) zero_ends++;
    end
    lv.position = ch_level[0];
    lv.speed    = ch_level[1];
    lv.torque   = ch_level[2];
    lv.zero     = zero_seen;
    return lv;
  endfunction

  task automatic offer_word(input meter_word_t wd, input logic typed, input rms_levels_t want);
    int gap;
    rms_levels_t lv;
    if (words_sent % 50 == 0) sender_rush = ($urandom_range(0, 3) == 0);
    gap = sender_rush ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata  <= IN_W'({wd.period, wd.weight, wd.smp});
    in_tuser  <= wd.kind;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    lv = meter_step(wd);
    levels_due.push_back(typed ? want : lv);
    words_sent++;
  endtask

  // stop offering until every pending result is back
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (levels_due.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_enable(input logic on);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= on;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    meter_on    = on;
    cfg_writes++;
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
    end
  endtask

  // driver
  initial begin
    meter_word_t wd;
    rms_levels_t want;
    int          n;
    int          stop_at;
    logic [31:0] wsum;
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = 1'b0;
    meter_on    = 1'b0;
    zero_seen   = 1'b0;
    for (int c = 0; c < wrms_pkg::NUM_CH; c++) begin
      ch_sum[c]   = '0;
      ch_level[c] = '0;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DRILL[i]) begin
      if (DRILL[i].cfg != CFG_KEEP) begin
        wait_idle();
        write_enable(DRILL[i].cfg == CFG_ON);
      end
      wd.kind   = DRILL[i].kind;
      wd.smp    = {DRILL[i].trq, DRILL[i].spd, DRILL[i].pos};
      wd.weight = DRILL[i].weight;
      wd.period = DRILL[i].period;
      want = {DRILL[i].e_zero, DRILL[i].e_trq, DRILL[i].e_spd, DRILL[i].e_pos};
      offer_word(wd, DRILL[i].typed, want);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      write_enable(PHASE_EN[ph]);
      stop_at = words_sent + PHASE_WORDS;
      while (words_sent < stop_at) begin
        if ($urandom_range(0, 99) < 15) begin
          // noise: anything at all
          wd.kind   = 1'($urandom);
          wd.smp    = {16'($urandom), 16'($urandom), 16'($urandom)};
          wd.weight = 16'($urandom);
          wd.period = $urandom;
          offer_word(wd, PREDICT, '0);
        end else begin
          // a run of samples closed by a period end
          n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : $urandom_range(1, 24);
          wsum = '0;
          repeat (n) begin
            wd.kind = KIND_SAMPLE;
            for (int c = 0; c < wrms_pkg::NUM_CH; c++) begin
              case ($urandom_range(0, 7))
                0: wd.smp[c] = 16'h8000;
                1: wd.smp[c] = 16'h7fff;
                2: wd.smp[c] = 16'h0000;
                3: wd.smp[c] = 16'hffff;
                4: wd.smp[c] = 16'($urandom_range(0, 511)) - 16'd256;
                default: wd.smp[c] = 16'($urandom);
              endcase
            end
            case ($urandom_range(0, 7))
              0: wd.weight = 16'h0000;
              1: wd.weight = 16'hffff;
              2: wd.weight = 16'h0001;
              default: wd.weight = 16'($urandom);
            endcase
            wd.period = $urandom;
            wsum += {16'd0, wd.weight};
            offer_word(wd, PREDICT, '0);
          end
          wd.kind = KIND_END;
          wd.smp  = {16'($urandom), 16'($urandom), 16'($urandom)};
          wd.weight = 16'($urandom);
          case ($urandom_range(0, 9))
            0: wd.period = '0;
            1: wd.period = $urandom;
            2: wd.period = 32'($urandom_range(1, 16));
            3: wd.period = 32'hffff_ffff;
            default: wd.period = wsum;
          endcase
          offer_word(wd, PREDICT, '0);
        end
      end
    end

    in_tvalid <= 1'b0;
    while (levels_due.size() != 0) @(posedge clk);
    // longest path is a period end through divider and root
    repeat (300) @(posedge clk);
    if (levels_due.size() != 0) begin
      mismatches++;
      $display("%0t: %0d results never arrived", $time, levels_due.size());
    end
    $display("%0d words sent, %0d results checked, %0d enabled period ends (%0d zero length)",
             words_sent, results_seen, ends_done, zero_ends);
    $display("%0d enable writes, one receiver hold-off of %0d cycles, %0d mismatches",
             cfg_writes, HOLD_CYCLES, mismatches);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // receiver
  initial begin
    int          pause;
    rms_levels_t want;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (!held && results_seen == HOLD_AT) begin
        // long stall so the queue fills and input backs up
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (results_seen % 50 == 0) taker_rush = ($urandom_range(0, 3) == 0);
      pause = taker_rush ? 0 : $urandom_range(0, 19);
      if (pause > 0) begin
        out_tready <= 1'b0;
        repeat (pause) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      results_seen++;
      if (levels_due.size() == 0) begin
        mismatches++;
        $display("%0t: result %h / %b with no word pending", $time, out_tdata, out_tuser);
      end else begin
        want = levels_due.pop_front();
        check_field("position_rms", want.position, out_tdata[15:0]);
        check_field("speed_rms", want.speed, out_tdata[31:16]);
        check_field("torque_rms", want.torque, out_tdata[47:32]);
        check_field("zero_period", {15'd0, want.zero}, {15'd0, out_tuser});
      end
    end
  end

endmodule
